[rtl/b64e_pkg.sv]
package b64e_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] FILL_NONE = 2'd0;
    localparam logic [1:0] FILL_ONE  = 2'd1;
    localparam logic [1:0] FILL_TWO  = 2'd2;

    localparam logic [2:0] NCHAR_TWO   = 3'd2;
    localparam logic [2:0] NCHAR_THREE = 3'd3;
    localparam logic [2:0] NCHAR_FOUR  = 3'd4;

    localparam logic [1:0] CHAR_LAST = 2'd3;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    typedef struct packed {
        logic [23:0] grp;
        logic [2:0]  nchar;
        logic        last;
    } grp_entry_t;

    function automatic logic [7:0] alpha_char(input logic [5:0] s);
        logic [7:0] v;
        v = {2'b00, s};
        if (s < 6'd26)
            alpha_char = 8'(8'd65 + v);
        else if (s < 6'd52)
            alpha_char = 8'(8'd71 + v);
        else if (s < 6'd62)
            alpha_char = 8'(v - 8'd4);
        else if (s == 6'd62)
            alpha_char = 8'h2B;
        else
            alpha_char = 8'h2F;
    endfunction

endpackage

[rtl/b64e_front.sv]
module b64e_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  logic [7:0]             data_byte,
    input  logic                   last_byte,
    output logic                   push,
    output b64e_pkg::grp_entry_t   push_entry
);

    logic [1:0] fill_reg, fill_next;
    logic [7:0] hi_reg, hi_next;
    logic [7:0] lo_reg, lo_next;

    always_comb
    begin
        fill_next        = fill_reg;
        hi_next          = hi_reg;
        lo_next          = lo_reg;
        push             = 1'b0;
        push_entry.grp   = {hi_reg, lo_reg, data_byte};
        push_entry.nchar = b64e_pkg::NCHAR_FOUR;
        push_entry.last  = last_byte;
        if (accept)
        begin
            unique case (fill_reg)
                b64e_pkg::FILL_ONE:
                begin
                    lo_next          = data_byte;
                    push_entry.grp   = {hi_reg, data_byte, 8'h00};
                    push_entry.nchar = b64e_pkg::NCHAR_THREE;
                    push             = last_byte;
                    fill_next        = last_byte ? b64e_pkg::FILL_NONE : b64e_pkg::FILL_TWO;
                end
                b64e_pkg::FILL_TWO:
                begin
                    push      = 1'b1;
                    fill_next = b64e_pkg::FILL_NONE;
                end
                default:
                begin
                    hi_next          = data_byte;
                    push_entry.grp   = {data_byte, 16'h0000};
                    push_entry.nchar = b64e_pkg::NCHAR_TWO;
                    push             = last_byte;
                    fill_next        = last_byte ? b64e_pkg::FILL_NONE : b64e_pkg::FILL_ONE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_reg <= b64e_pkg::FILL_NONE;
        else
            fill_reg <= fill_next;
    end

    always_ff @(posedge clk)
    begin
        hi_reg <= hi_next;
        lo_reg <= lo_next;
    end

endmodule

[rtl/b64e_queue.sv]
module b64e_queue #(
    parameter int DEPTH = b64e_pkg::QUEUE_DEPTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  b64e_pkg::grp_entry_t   push_entry,
    input  logic                   pop,
    output logic                   full,
    output logic                   not_empty,
    output b64e_pkg::grp_entry_t   head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_MAX = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(DEPTH);

    b64e_pkg::grp_entry_t slot_reg [DEPTH];
    logic [PW-1:0] wr_reg, wr_next;
    logic [PW-1:0] rd_reg, rd_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    assign full      = (cnt_reg == CNT_MAX);
    assign not_empty = (cnt_reg != '0);
    assign head      = slot_reg[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
            wr_next = (wr_reg == PTR_MAX) ? '0 : PW'(wr_reg + 1'b1);
        if (pop)
            rd_next = (rd_reg == PTR_MAX) ? '0 : PW'(rd_reg + 1'b1);
        if (push && !pop)
            cnt_next = CW'(cnt_reg + 1'b1);
        else if (pop && !push)
            cnt_next = CW'(cnt_reg - 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_reg] <= push_entry;
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("queue written while full");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n) pop |-> not_empty)
        else $error("queue read while empty");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= CNT_MAX)
        else $error("queue count out of range");

endmodule

[rtl/b64e_back.sv]
module b64e_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   head_valid,
    input  b64e_pkg::grp_entry_t   head,
    output logic                   pop,
    output logic                   ovalid,
    input  logic                   oready,
    output logic [7:0]             out_char,
    output logic                   last_char
);

    b64e_pkg::grp_entry_t work_reg;
    logic       busy_reg, busy_next;
    logic [1:0] idx_reg, idx_next;
    logic       ov_reg, ov_next;
    logic [7:0] oc_reg;
    logic       ol_reg;
    logic       emit_go;
    logic [5:0] sextet;
    logic [7:0] ch;

    assign emit_go = busy_reg && (!ov_reg || oready);
    assign pop     = head_valid && (!busy_reg || (emit_go && idx_reg == b64e_pkg::CHAR_LAST));

    always_comb
    begin
        unique case (idx_reg)
            2'd0:    sextet = work_reg.grp[23:18];
            2'd1:    sextet = work_reg.grp[17:12];
            2'd2:    sextet = work_reg.grp[11:6];
            default: sextet = work_reg.grp[5:0];
        endcase
        if ({1'b0, idx_reg} >= work_reg.nchar)
            ch = b64e_pkg::PAD_CHAR;
        else
            ch = b64e_pkg::alpha_char(sextet);
    end

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        ov_next   = ov_reg;
        if (pop)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
        end
        else if (emit_go)
        begin
            idx_next = 2'(idx_reg + 1'b1);
            if (idx_reg == b64e_pkg::CHAR_LAST)
                busy_next = 1'b0;
        end
        if (emit_go)
            ov_next = 1'b1;
        else if (oready)
            ov_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
            ov_reg   <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            work_reg <= head;
        if (emit_go)
        begin
            oc_reg <= ch;
            ol_reg <= (idx_reg == b64e_pkg::CHAR_LAST) && work_reg.last;
        end
    end

    assign ovalid    = ov_reg;
    assign out_char  = oc_reg;
    assign last_char = ol_reg;

    a_idle_idx: assert property (@(posedge clk) disable iff (!rst_n) !busy_reg |-> idx_reg == '0)
        else $error("character index moved while idle");
    a_first_not_pad: assert property (@(posedge clk) disable iff (!rst_n)
        emit_go && idx_reg == 2'd1 |=> oc_reg != b64e_pkg::PAD_CHAR)
        else $error("padding on second character");

endmodule

[rtl/base64_byte_encoder_unit.sv]
// Flow: a group completed by an accepted byte (or closed by the last flag) is written
// into the group queue, popped into the emitter once the emitter is free, and its first
// character is registered. Throughput: one byte accepted per cycle while the queue has
// room; the emitter sends one character per cycle while m_tready allows, four per group.
// Reset: asynchronous, active low; clears group fill, queue pointers and output valid.
module base64_byte_encoder_unit #(
    parameter int QUEUE_DEPTH = b64e_pkg::QUEUE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_char
    output logic       m_tlast
);

    logic                 accept;
    logic                 push;
    logic                 pop;
    logic                 full;
    logic                 not_empty;
    b64e_pkg::grp_entry_t push_entry;
    b64e_pkg::grp_entry_t head;

    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;

    b64e_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .data_byte  (s_tdata),
        .last_byte  (s_tlast),
        .push       (push),
        .push_entry (push_entry)
    );

    b64e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (full),
        .not_empty  (not_empty),
        .head       (head)
    );

    b64e_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (not_empty),
        .head       (head),
        .pop        (pop),
        .ovalid     (m_tvalid),
        .oready     (m_tready),
        .out_char   (m_tdata),
        .last_char  (m_tlast)
    );

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps

module tb;

    typedef struct {
        bit [7:0] code;
        bit       tail;
    } enc_char_t;

    class b64_scoreboard_t;
        bit [1:0]  group_fill;
        bit [15:0] held_bytes;
        enc_char_t chars_due[$];
        int        err_count;
        int        bytes_seen;
        int        chars_seen;
        int        msgs_seen;

        function new();
            group_fill = b64e_pkg::FILL_NONE;
            held_bytes = '0;
            err_count  = 0;
            bytes_seen = 0;
            chars_seen = 0;
            msgs_seen  = 0;
        endfunction

        function bit [7:0] symbol(bit [5:0] s);
            string alpha;
            alpha = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
            return alpha.getc(s);
        endfunction

        function void note_byte(bit [7:0] b, bit l);
            bit [1:0]  fill;
            bit [23:0] grp;
            int        nsym;
            enc_char_t c;
            fill = group_fill;
            bytes_seen++;
            if (fill != b64e_pkg::FILL_ONE && fill != b64e_pkg::FILL_TWO)
                fill = b64e_pkg::FILL_NONE;
            if (fill == b64e_pkg::FILL_NONE)
            begin
                held_bytes = {b, 8'h00};
                group_fill = b64e_pkg::FILL_ONE;
                if (!l)
                    return;
                grp  = {held_bytes, 8'h00};
                nsym = 2;
            end
            else if (fill == b64e_pkg::FILL_ONE)
            begin
                held_bytes = {held_bytes[15:8], b};
                group_fill = b64e_pkg::FILL_TWO;
                if (!l)
                    return;
                grp  = {held_bytes, 8'h00};
                nsym = 3;
            end
            else
            begin
                grp  = {held_bytes, b};
                nsym = 4;
            end
            for (int i = 0; i < 4; i++)
            begin
                c.code = (i < nsym) ? symbol(grp[23 - 6 * i -: 6]) : b64e_pkg::PAD_CHAR;
                c.tail = (i == 3) ? l : 1'b0;
                chars_due = {chars_due, c};
            end
            if (l)
                msgs_seen++;
            group_fill = b64e_pkg::FILL_NONE;
            held_bytes = '0;
        endfunction

        task report(string what);
            $display("[%0t] mismatch: %s", $time, what);
            err_count++;
        endtask

        task check_char(bit [7:0] code, bit tail);
            enc_char_t c;
            chars_seen++;
            if (chars_due.size() == 0)
            begin
                report($sformatf("unexpected character 0x%02h last=%0b", code, tail));
                return;
            end
            c = chars_due.pop_front();
            if (code !== c.code)
                report($sformatf("char 0x%02h, want 0x%02h", code, c.code));
            if (tail !== c.tail)
                report($sformatf("last %0b, want %0b on char 0x%02h", tail, c.tail, c.code));
        endtask
    endclass

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic       m_tlast;

    b64_scoreboard_t sb;
    int send_idle;
    int recv_stall;
    int phase_count;

    base64_byte_encoder_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task send_byte(input bit [7:0] d, input bit l);
        if ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
            while ($urandom_range(99) < send_idle)
                @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tlast  <= l;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_byte(d, l);
        @(negedge clk);
    endtask

    task send_random_message(input int max_len);
        int len;
        len = $urandom_range(max_len, 1);
        for (int i = 1; i <= len; i++)
            send_byte(8'($urandom), i == len);
    endtask

    task hold_until_drained();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (sb.chars_due.size() != 0)
            @(negedge clk);
    endtask

    task run_phase(input int idle_pct, input int stall_pct, input int n_bytes);
        int start;
        send_idle  = idle_pct;
        recv_stall = stall_pct;
        start      = sb.bytes_seen;
        phase_count++;
        while (sb.bytes_seen - start < n_bytes)
        begin
            if ($urandom_range(3) == 0)
                send_random_message(2);
            else
                send_random_message(14);
            if ($urandom_range(19) == 0)
                hold_until_drained();
        end
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                sb.check_char(m_tdata, m_tlast);
            @(negedge clk);
            m_tready <= ($urandom_range(99) >= recv_stall);
        end
    end

    initial
    begin
        sb          = new();
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        m_tready    = 1'b0;
        send_idle   = 0;
        recv_stall  = 0;
        phase_count = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hF8, 1'b0);
        send_byte(8'h01, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h4D, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h6E, 1'b0);
        send_byte(8'hFB, 1'b1);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'hFC, 1'b1);
        send_byte(8'h10, 1'b0);
        send_byte(8'h83, 1'b0);
        send_byte(8'hBF, 1'b1);
        hold_until_drained();

        run_phase(0, 0, 60);
        run_phase(87, 0, 60);
        hold_until_drained();
        run_phase(0, 87, 60);
        run_phase(37, 37, 60);
        run_phase(0, 0, 15);

        s_tvalid <= 1'b0;
        while (sb.chars_due.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);

        $display("Encoded %0d messages from %0d bytes into %0d characters",
                 sb.msgs_seen, sb.bytes_seen, sb.chars_seen);
        $display("Covered %0d random phases with sender gaps and receiver stalls",
                 phase_count);
        if (sb.err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
